// ----- design/assert_macros.svh -----
// assertion macros for the checker file
// depends on nothing; taken in by `include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, ignored during reset
`define CHK_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// antecedent implies consequent in the next cycle, ignored during reset
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

// antecedent implies consequent in the next cycle, checked through reset too
`define CHK_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("check failed");

`endif

// ----- design/scfr_pkg.sv -----
// shared types and constants for the serial command frame receiver
// depends on nothing
package scfr_pkg;

   localparam int StoreDepth = 11;
   localparam logic [3:0] CheckPos = 4'd10;
   localparam logic [3:0] FrameLastPos = 4'd11;

   localparam logic [7:0] HeaderReset = 8'd123;
   localparam logic [7:0] TailReset = 8'd125;

   // register index taken from paddr bit 2
   typedef enum logic {
      REG_HEADER = 1'b0,
      REG_TAIL   = 1'b1
   } reg_index_type;

   typedef logic [StoreDepth-1:0][7:0] frame_store_type;

   // what the assembler hands to the frame checker
   typedef struct packed {
      logic            fire;
      logic [7:0]      last_byte;
      logic [7:0]      xor_sum;
      frame_store_type store;
   } asm_out_type;

   typedef struct packed {
      logic        x_reversed;
      logic [7:0]  steer_mode;
      logic [7:0]  scratch_cmd;
      logic [15:0] move_z;
      logic [15:0] move_y;
      logic [15:0] move_x;
   } rsp_payload_type;

endpackage

// ----- design/serial_command_frame_receiver.sv -----
// the request carrying the tail byte has its result registered in the result or skid stage
// throughput: one request per cycle; ready drops only while both result stages are full
// the frame store is written in the accepting cycle, checked and decoded in the same path
// reset: synchronous, active high; clears capture state, count, xor, result valids
// and returns header/tail to 123/125; frame bytes are not cleared
// depends on scfr_pkg and the assembler, checker and result-stage modules
module serial_command_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   // byte stream in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] manual_override
   // decoded commands out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [15:0] move_x, [31:16] move_y, [47:32] move_z,
                                    // [55:48] scratch_cmd, [63:56] steer_mode,
                                    // [64] x_reversed, [71:65] zero
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]                header_ff, header_in;
   logic [7:0]                tail_ff, tail_in;
   logic                      csr_wr;
   scfr_pkg::reg_index_type   csr_index;
   logic                      req_accept;
   scfr_pkg::asm_out_type     asm_out;
   logic                      frame_ok;
   scfr_pkg::rsp_payload_type payload;
   scfr_pkg::rsp_payload_type rsp_payload;

   // register port, word offsets 0 and 4; low address bits are byte offsets
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = scfr_pkg::reg_index_type'(csr_paddr[2]);

   always_comb begin
      header_in = header_ff;
      tail_in   = tail_ff;
      if (csr_wr) begin
         case (csr_index)
            scfr_pkg::REG_HEADER: header_in = csr_pwdata[7:0];
            scfr_pkg::REG_TAIL:   tail_in   = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         scfr_pkg::REG_HEADER: csr_prdata = {24'd0, header_ff};
         scfr_pkg::REG_TAIL:   csr_prdata = {24'd0, tail_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= scfr_pkg::HeaderReset;
         tail_ff   <= scfr_pkg::TailReset;
      end else begin
         header_ff <= header_in;
         tail_ff   <= tail_in;
      end
   end

   // a request is taken whenever the skid stage is free
   assign req_accept = req_tvalid && req_tready;

   // capture, count and store bytes; flags the twelfth byte
   scfr_frame_asm u_asm (
      .clock           (clock),
      .reset           (reset),
      .byte_valid      (req_accept),
      .rx_byte         (req_tdata),
      .manual_override (req_tuser),
      .header_byte     (header_ff),
      .asm_out         (asm_out)
   );

   // judge the frame on its twelfth byte and decode the motion fields
   scfr_frame_check u_check (
      .asm_out     (asm_out),
      .header_byte (header_ff),
      .tail_byte   (tail_ff),
      .frame_ok    (frame_ok),
      .payload     (payload)
   );

   // result register plus skid, so a waiting result never blocks the byte stream at once
   scfr_rsp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (frame_ok),
      .in_data   (payload),
      .in_room   (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_payload)
   );

   assign rsp_tdata = {7'd0,
                       rsp_payload.x_reversed,
                       rsp_payload.steer_mode,
                       rsp_payload.scratch_cmd,
                       rsp_payload.move_z,
                       rsp_payload.move_y,
                       rsp_payload.move_x};

endmodule

// ----- design/scfr_frame_asm.sv -----
// frame assembler: capture state, byte count, frame store and running xor
// depends on scfr_pkg
module scfr_frame_asm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_valid,
   input  logic [7:0]           rx_byte,
   input  logic                 manual_override,
   input  logic [7:0]           header_byte,
   output scfr_pkg::asm_out_type asm_out
);

   logic                      capturing_ff, capturing_in;
   logic [3:0]                count_ff, count_in;
   logic [7:0]                xor_ff, xor_in;
   scfr_pkg::frame_store_type store_ff;
   logic                      live;
   logic                      cap_now;
   logic                      store_wr;
   logic                      fire;

   assign live     = byte_valid && !manual_override;
   assign cap_now  = capturing_ff || (rx_byte == header_byte);
   assign store_wr = live && cap_now && (count_ff < scfr_pkg::FrameLastPos);
   assign fire     = live && cap_now && (count_ff >= scfr_pkg::FrameLastPos);

   always_comb begin
      capturing_in = capturing_ff;
      count_in     = count_ff;
      xor_in       = xor_ff;
      if (live) begin
         if (!cap_now) begin
            count_in = 4'd0;
            xor_in   = 8'd0;
         end else if (store_wr) begin
            capturing_in = 1'b1;
            count_in     = count_ff + 4'd1;
            if (count_ff < scfr_pkg::CheckPos) begin
               xor_in = xor_ff ^ rx_byte;
            end
         end else begin
            // twelfth byte ends capture whatever the verdict
            capturing_in = 1'b0;
            count_in     = 4'd0;
            xor_in       = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capturing_ff <= 1'b0;
         count_ff     <= 4'd0;
         xor_ff       <= 8'd0;
      end else begin
         capturing_ff <= capturing_in;
         count_ff     <= count_in;
         xor_ff       <= xor_in;
      end
   end

   // frame bytes, no reset: each is written in the frame before it is read
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_ff[count_ff] <= rx_byte;
      end
   end

   assign asm_out.fire      = fire;
   assign asm_out.last_byte = rx_byte;
   assign asm_out.xor_sum   = xor_ff;
   assign asm_out.store     = store_ff;

endmodule

// ----- design/scfr_frame_check.sv -----
// frame checker: tail, header and checksum tests and field decode
// depends on scfr_pkg
module scfr_frame_check (
   input  scfr_pkg::asm_out_type     asm_out,
   input  logic [7:0]                header_byte,
   input  logic [7:0]                tail_byte,
   output logic                      frame_ok,
   output scfr_pkg::rsp_payload_type payload
);

   logic [15:0] raw_x;
   logic        rev;

   assign frame_ok = asm_out.fire
                     && (asm_out.last_byte == tail_byte)
                     && (asm_out.store[0] == header_byte)
                     && (asm_out.store[scfr_pkg::CheckPos] == asm_out.xor_sum);

   assign raw_x = {asm_out.store[1], asm_out.store[2]};
   assign rev   = (asm_out.store[9] != 8'd0);

   always_comb begin
      payload.move_x = raw_x;
      if (rev) begin
         // most negative value saturates on negation
         payload.move_x = (raw_x == 16'h8000) ? 16'h7FFF : (16'd0 - raw_x);
      end
      payload.move_y      = {asm_out.store[3], asm_out.store[4]};
      payload.move_z      = {asm_out.store[5], asm_out.store[6]};
      payload.scratch_cmd = asm_out.store[7];
      payload.steer_mode  = asm_out.store[8];
      payload.x_reversed  = rev;
   end

endmodule

// ----- design/scfr_rsp_skid.sv -----
// result register with a skid stage behind it
// depends on scfr_pkg
module scfr_rsp_skid (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  scfr_pkg::rsp_payload_type in_data,
   output logic                      in_room,
   output logic                      out_valid,
   input  logic                      out_ready,
   output scfr_pkg::rsp_payload_type out_data
);

   logic                      out_valid_ff, out_valid_in;
   logic                      skid_valid_ff, skid_valid_in;
   scfr_pkg::rsp_payload_type out_data_ff, out_data_in;
   scfr_pkg::rsp_payload_type skid_data_ff, skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = in_valid;
            skid_data_in  = in_data;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_room   = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ----- design/scfr_checker.sv -----
// port-level checks on the serial command frame receiver, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module scfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   // a stalled result holds
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // a result only appears after a request was taken
   `CHK_SAME(a_rsp_cause, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready))

   // back-pressure only with a result pending
   `CHK_SAME(a_stall_cause, clock, reset, !req_tready, rsp_tvalid)

   // a reversed x never shows the most negative value
   `CHK_SAME(a_x_sat, clock, reset, rsp_tvalid && rsp_tdata[64], rsp_tdata[15:0] != 16'h8000)

   // out of reset the block is empty and ready
   `CHK_NEXT_ALWAYS(a_reset_empty, clock, reset, req_tready && !rsp_tvalid)

endmodule

bind serial_command_frame_receiver scfr_checker u_scfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
